// ===== sv/sbph_pkg.sv =====
// Shared types, constants and elaboration-time tables for the spectrum band peak-hold block.
// Holds the band edge tables and the octave threshold table of the 30*ln(x) height function.
// No dependencies; every other file of the block refers to it by scoped names.
package sbph_pkg;

  localparam int MAX_BANDS_DEF = 80;
  localparam int USED_BINS_DEF = 255;
  localparam int BANDS_20      = 20;

  localparam int BIN_W    = 16;
  localparam int MAG_W    = 15;
  localparam int BAND_W   = 7;
  localparam int COUNT_W  = 8;
  localparam int HEIGHT_W = 9;
  localparam int PIX_W    = 12;

  localparam logic [HEIGHT_W-1:0] HEIGHT_CAP      = 9'd380;
  localparam logic [PIX_W-1:0]    PEAK_DECAY_STEP = 12'd1;
  localparam logic [HEIGHT_W-1:0] BAR_FALL_STEP   = 9'd5;
  localparam logic [PIX_W-1:0]    PIC_HEIGHT_RST  = 12'd400;

  localparam logic [63:0] THIRTY_LN2_Q32 = 64'd89311334155;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EIGHTY_BANDS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_PEAKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_HEIGHT = 2'd2;

  typedef struct packed {
    logic             eighty_bands;
    logic             show_peaks;
    logic [PIX_W-1:0] picture_height;
  } cfg_t;

  localparam logic [7:0] EDGES20 [21] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd15, 8'd20, 8'd27,
    8'd36, 8'd47, 8'd62, 8'd82, 8'd107, 8'd141, 8'd184, 8'd255};

  localparam logic [7:0] EDGES80 [81] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
    8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
    8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36,
    8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48,
    8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd61,
    8'd63, 8'd67, 8'd72, 8'd77, 8'd82, 8'd87, 8'd93, 8'd99, 8'd105, 8'd110, 8'd115,
    8'd121, 8'd130, 8'd141, 8'd152, 8'd163, 8'd174, 8'd185, 8'd200, 8'd255};

  // One row of height thresholds per octave of the magnitude.
  localparam int LOG_OCTAVES = 15;
  localparam int THR_COLS    = 22;
  localparam int THR_W       = 16;

  typedef logic [LOG_OCTAVES-1:0][THR_COLS-1:0][THR_W-1:0] thr_tab_t;
  typedef logic [LOG_OCTAVES-1:0][HEIGHT_W-1:0]            thr_base_t;

  // Exact fixed-point floor(30*ln(y)), evaluated only at elaboration to build the tables.
  function automatic logic [HEIGHT_W-1:0] log_height(input logic [MAG_W-1:0] y);
    logic [3:0]  n;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] lg;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] acc;
    n    = '0;
    frac = '0;
    if (y == '0) begin
      return '0;
    end
    for (int i = 1; i < MAG_W; i++) begin
      if ((y >> i) != '0) begin
        n = 4'(i);
      end
    end
    m = 64'(y) << (30 - int'(n));
    for (int i = 0; i < 32; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        frac = frac | 64'd1;
      end
    end
    lg  = (64'(n) << 32) | frac;
    hi  = lg >> 18;
    lo  = lg & 64'h3FFFF;
    acc = hi * THIRTY_LN2_Q32 + ((lo * THIRTY_LN2_Q32) >> 18);
    return HEIGHT_W'(acc >> 46);
  endfunction

  // Smallest magnitude whose height reaches h; 32768 when none does.
  function automatic logic [THR_W-1:0] log_threshold(input int unsigned h);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 1;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (int'(log_height(MAG_W'(mid))) >= int'(h)) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return THR_W'(lo);
  endfunction

  function automatic thr_base_t build_thr_base();
    thr_base_t b;
    for (int n = 0; n < LOG_OCTAVES; n++) begin
      b[n] = log_height(MAG_W'(1 << n));
    end
    return b;
  endfunction

  function automatic thr_tab_t build_thr_tab();
    thr_tab_t    t;
    int unsigned b;
    for (int n = 0; n < LOG_OCTAVES; n++) begin
      b = int'(log_height(MAG_W'(1 << n)));
      for (int j = 0; j < THR_COLS; j++) begin
        t[n][j] = log_threshold(b + 1 + j);
      end
    end
    return t;
  endfunction

  localparam thr_base_t THR_BASE = build_thr_base();
  localparam thr_tab_t  THR_TAB  = build_thr_tab();

endpackage

// ===== sv/sbph_log_height.sv =====
// Combinational floor(30*ln(y)) for a 15-bit magnitude, zero for a zero magnitude.
// Finds the octave, then counts the thresholds of that octave from sbph_pkg.
module sbph_log_height (
  input  logic [sbph_pkg::MAG_W-1:0]    mag_i,
  output logic [sbph_pkg::HEIGHT_W-1:0] height_o
);

  logic [3:0]                         octave;
  logic [sbph_pkg::THR_COLS-1:0]      reached;
  logic [$clog2(sbph_pkg::THR_COLS+1)-1:0] count;

  always_comb begin
    octave = '0;
    for (int i = 0; i < sbph_pkg::MAG_W; i++) begin
      if (mag_i[i]) begin
        octave = 4'(i);
      end
    end
  end

  // Thresholds are sorted, so the compare results form a thermometer code.
  always_comb begin
    for (int j = 0; j < sbph_pkg::THR_COLS; j++) begin
      reached[j] = {1'b0, mag_i} >= sbph_pkg::THR_TAB[octave][j];
    end
    count = $bits(count)'($countones(reached));
  end

  assign height_o = sbph_pkg::THR_BASE[octave] + sbph_pkg::HEIGHT_W'(count);

endmodule

// ===== sv/sbph_band_store.sv =====
// Per-band peak and previous-bar store: one memory with registered read, valid bits
// that make unwritten bands read as zero, and forwarding of a same-cycle write.
module sbph_band_store #(
  parameter int DEPTH = sbph_pkg::MAX_BANDS_DEF,
  parameter int WIDTH = sbph_pkg::PIX_W + sbph_pkg::HEIGHT_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        fwd_q    <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_data_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

// ===== sv/sbph_hold_update.sv =====
// Band-end update: peak-hold decay, bar fall limit and the picture-height clamps.
// Purely combinational; uses the configuration struct from sbph_pkg.
module sbph_hold_update (
  input  sbph_pkg::cfg_t                cfg_i,
  input  logic [sbph_pkg::HEIGHT_W-1:0] height_i,
  input  logic [sbph_pkg::PIX_W-1:0]    peak_old_i,
  input  logic [sbph_pkg::HEIGHT_W-1:0] prev_old_i,
  output logic [sbph_pkg::PIX_W-1:0]    peak_new_o,
  output logic [sbph_pkg::HEIGHT_W-1:0] prev_new_o,
  output logic [sbph_pkg::PIX_W-1:0]    bar_o
);

  logic [sbph_pkg::PIX_W-1:0]    height_ext;
  logic [sbph_pkg::PIX_W-1:0]    peak;
  logic [sbph_pkg::HEIGHT_W-1:0] fall;
  logic [sbph_pkg::PIX_W-1:0]    fall_ext;
  logic [sbph_pkg::PIX_W-1:0]    ph;

  assign height_ext = sbph_pkg::PIX_W'(height_i);
  assign ph         = cfg_i.picture_height;

  always_comb begin
    peak = peak_old_i;
    priority if (height_ext > peak_old_i) begin
      peak = height_ext;
    end else if (peak_old_i != '0) begin
      peak = peak_old_i - sbph_pkg::PEAK_DECAY_STEP;
      if (peak < height_ext) begin
        peak = height_ext;
      end
    end else begin
      peak = peak_old_i;
    end
    if (peak != '0 && cfg_i.show_peaks && peak >= ph) begin
      peak = (ph >= 12'd2) ? ph - 12'd2 : '0;
    end
  end

  // The bar never drops by more than the fall speed per frame.
  always_comb begin
    fall = height_i;
    if (prev_old_i >= sbph_pkg::BAR_FALL_STEP &&
        height_i <= prev_old_i - sbph_pkg::BAR_FALL_STEP) begin
      fall = prev_old_i - sbph_pkg::BAR_FALL_STEP;
    end
  end

  assign fall_ext   = sbph_pkg::PIX_W'(fall);
  assign peak_new_o = peak;
  assign prev_new_o = fall;
  assign bar_o      = (fall_ext > ph) ? ph : fall_ext;

endmodule

// ===== sv/spectrum_band_peak_hold_top.sv =====
// A band's last bin yields a result through the input, band-end and result registers.
// Throughput: one bin per cycle; the input, band and result registers advance together
// and hold only while a finished result waits on out_ready_i.
// Other bins give no result. Reset clears bin, band and maximum counters and the valid
// bits of the band store, so every band's peak and previous bar read as zero.
// Configuration resets to 20 bands, peaks shown, picture height 400.
module spectrum_band_peak_hold_top #(
  parameter int MAX_BANDS = sbph_pkg::MAX_BANDS_DEF,
  parameter int USED_BINS = sbph_pkg::USED_BINS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sbph_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sbph_pkg::PIX_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sbph_pkg::BIN_W-1:0]    bin_value_i,
  input  logic                                 first_bin_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sbph_pkg::BAND_W-1:0]          band_index_o,
  output logic [sbph_pkg::PIX_W-1:0]           bar_height_o,
  output logic [sbph_pkg::PIX_W-1:0]           peak_height_o,
  output logic                                 last_band_o
);

  localparam int AW      = $clog2(MAX_BANDS);
  localparam int STORE_W = sbph_pkg::PIX_W + sbph_pkg::HEIGHT_W;

  sbph_pkg::cfg_t cfg_q;

  logic en;

  // Input register.
  logic                              s0_valid_q;
  logic signed [sbph_pkg::BIN_W-1:0] s0_bin_q;
  logic                              s0_first_q;

  // Frame state.
  logic [sbph_pkg::COUNT_W-1:0] bin_q, bin_d;
  logic [sbph_pkg::BAND_W-1:0]  band_q, band_d;
  logic [sbph_pkg::MAG_W-1:0]   bmax_q, bmax_d;

  // Band-end register.
  logic                          s1_valid_q;
  logic [sbph_pkg::BAND_W-1:0]   s1_band_q;
  logic [sbph_pkg::HEIGHT_W-1:0] s1_height_q;
  logic                          s1_last_q;

  // Result register.
  logic                       out_valid_q;
  logic [sbph_pkg::BAND_W-1:0] out_band_q;
  logic [sbph_pkg::PIX_W-1:0] out_bar_q;
  logic [sbph_pkg::PIX_W-1:0] out_peak_q;
  logic                       out_last_q;

  logic [sbph_pkg::COUNT_W-1:0]  bin;
  logic [sbph_pkg::BAND_W-1:0]   band;
  logic [sbph_pkg::BAND_W-1:0]   band_next;
  logic [sbph_pkg::MAG_W-1:0]    bmax;
  logic [sbph_pkg::MAG_W-1:0]    new_max;
  logic [sbph_pkg::BAND_W-1:0]   num_bands;
  logic [7:0]                    band_end;
  logic                          active;
  logic                          close;
  logic                          last;
  logic [sbph_pkg::HEIGHT_W-1:0] log_h;
  logic [sbph_pkg::HEIGHT_W-1:0] height;

  logic [STORE_W-1:0]            rd_data;
  logic [STORE_W-1:0]            wr_data;
  logic [sbph_pkg::PIX_W-1:0]    peak_new;
  logic [sbph_pkg::HEIGHT_W-1:0] prev_new;
  logic [sbph_pkg::PIX_W-1:0]    bar;

  // The whole pipeline moves unless a result is waiting.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eighty_bands   <= 1'b0;
      cfg_q.show_peaks     <= 1'b1;
      cfg_q.picture_height <= sbph_pkg::PIC_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbph_pkg::CFG_EIGHTY_BANDS:   cfg_q.eighty_bands   <= cfg_data_i[0];
        sbph_pkg::CFG_SHOW_PEAKS:     cfg_q.show_peaks     <= cfg_data_i[0];
        sbph_pkg::CFG_PICTURE_HEIGHT: cfg_q.picture_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      s0_bin_q   <= bin_value_i;
      s0_first_q <= first_bin_i;
    end
  end

  // Bin and band tracking; a first bin restarts the frame before it is counted.
  always_comb begin
    bin       = s0_first_q ? '0 : bin_q;
    band      = s0_first_q ? '0 : band_q;
    bmax      = s0_first_q ? '0 : bmax_q;
    band_next = band + 7'd1;
    num_bands = cfg_q.eighty_bands ? sbph_pkg::BAND_W'(MAX_BANDS)
                                   : sbph_pkg::BAND_W'(sbph_pkg::BANDS_20);
    last      = band_next == num_bands;
    active    = (bin < 8'(USED_BINS)) && (band < num_bands);
    new_max   = (!s0_bin_q[sbph_pkg::BIN_W-1] && s0_bin_q[sbph_pkg::MAG_W-1:0] > bmax)
                ? s0_bin_q[sbph_pkg::MAG_W-1:0] : bmax;
    if (last) begin
      band_end = 8'(USED_BINS);
    end else if (cfg_q.eighty_bands) begin
      band_end = sbph_pkg::EDGES80[band_next];
    end else begin
      band_end = sbph_pkg::EDGES20[band_next[4:0]];
    end
    close  = active && ({1'b0, bin} + 9'd1 >= {1'b0, band_end});
    bin_d  = (bin != 8'hFF) ? bin + 8'd1 : bin;
    band_d = close ? band_next : band;
    if (close) begin
      bmax_d = '0;
    end else if (active) begin
      bmax_d = new_max;
    end else begin
      bmax_d = bmax;
    end
  end

  sbph_log_height u_log_height (
    .mag_i    (new_max),
    .height_o (log_h)
  );

  assign height = (log_h > sbph_pkg::HEIGHT_CAP) ? sbph_pkg::HEIGHT_CAP : log_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q      <= '0;
      band_q     <= '0;
      bmax_q     <= '0;
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q && close;
      if (s0_valid_q) begin
        bin_q  <= bin_d;
        band_q <= band_d;
        bmax_q <= bmax_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s0_valid_q && close) begin
      s1_band_q   <= band;
      s1_height_q <= height;
      s1_last_q   <= last;
    end
  end

  assign wr_data = {peak_new, prev_new};

  sbph_band_store #(
    .DEPTH (MAX_BANDS),
    .WIDTH (STORE_W)
  ) u_band_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (en && s0_valid_q && close),
    .rd_addr_i (band[AW-1:0]),
    .wr_en_i   (en && s1_valid_q),
    .wr_addr_i (s1_band_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  sbph_hold_update u_hold_update (
    .cfg_i      (cfg_q),
    .height_i   (s1_height_q),
    .peak_old_i (rd_data[STORE_W-1:sbph_pkg::HEIGHT_W]),
    .prev_old_i (rd_data[sbph_pkg::HEIGHT_W-1:0]),
    .peak_new_o (peak_new),
    .prev_new_o (prev_new),
    .bar_o      (bar)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      out_band_q <= s1_band_q;
      out_bar_q  <= bar;
      out_peak_q <= peak_new;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign band_index_o  = out_band_q;
  assign bar_height_o  = out_bar_q;
  assign peak_height_o = out_peak_q;
  assign last_band_o   = out_last_q;

  a_out_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> band_index_o < sbph_pkg::BAND_W'(MAX_BANDS))
    else $error("reported band beyond band count");

  a_bar_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bar_height_o <= sbph_pkg::PIX_W'(sbph_pkg::HEIGHT_CAP))
    else $error("bar above height cap");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_band_end_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_band_q < sbph_pkg::BAND_W'(MAX_BANDS) &&
                    s1_height_q <= sbph_pkg::HEIGHT_CAP))
    else $error("band end out of range");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for spectrum_band_peak_hold_top: bins are streamed and band results
// checked field by field against a predictor of band maxima, log height, peak-hold and fall limit.
// Depends on sbph_pkg (widths, register indexes, band edge tables) and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic [sbph_pkg::BAND_W-1:0] band;
    logic [sbph_pkg::PIX_W-1:0]  bar;
    logic [sbph_pkg::PIX_W-1:0]  peak;
    logic                        last;
  } band_result_t;

  typedef struct packed {
    logic signed [sbph_pkg::BIN_W-1:0] value;
    logic                              first;
    logic                              typed;
    band_result_t                      want;
  } bin_row_t;

  // Rows with typed set carry a result read straight off the behavior; the rest are predicted.
  localparam bin_row_t DIRECTED_BINS [17] = '{
    '{16'sd0,      1'b1, 1'b1, '{7'd0, 12'd0,   12'd0,   1'b0}},
    '{16'sd1,      1'b0, 1'b1, '{7'd1, 12'd0,   12'd0,   1'b0}},
    '{16'sd32767,  1'b0, 1'b1, '{7'd2, 12'd311, 12'd311, 1'b0}},
    '{-16'sd32768, 1'b0, 1'b1, '{7'd3, 12'd0,   12'd0,   1'b0}},
    '{-16'sd1,     1'b0, 1'b1, '{7'd4, 12'd0,   12'd0,   1'b0}},
    '{16'sd2,      1'b0, 1'b1, '{7'd5, 12'd20,  12'd20,  1'b0}},
    '{16'sd16384,  1'b0, 1'b0, '0},
    '{16'sd100,    1'b0, 1'b0, '0},
    '{16'sd5,      1'b0, 1'b0, '0},
    '{16'sd300,    1'b0, 1'b0, '0},
    '{-16'sd7,     1'b0, 1'b0, '0},
    '{16'sd32767,  1'b1, 1'b1, '{7'd0, 12'd311, 12'd311, 1'b0}},
    '{16'sd0,      1'b0, 1'b1, '{7'd1, 12'd0,   12'd0,   1'b0}},
    '{16'sd0,      1'b0, 1'b1, '{7'd2, 12'd306, 12'd310, 1'b0}},
    '{16'sd32767,  1'b1, 1'b1, '{7'd0, 12'd311, 12'd311, 1'b0}},
    '{16'sd1,      1'b0, 1'b1, '{7'd1, 12'd0,   12'd0,   1'b0}},
    '{16'sd32767,  1'b0, 1'b1, '{7'd2, 12'd311, 12'd311, 1'b0}}
  };

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               cfg_we     = 1'b0;
  logic [sbph_pkg::CFG_IDX_W-1:0]     cfg_idx    = sbph_pkg::CFG_EIGHTY_BANDS;
  logic [sbph_pkg::PIX_W-1:0]         cfg_data   = '0;
  logic                               in_valid   = 1'b0;
  logic signed [sbph_pkg::BIN_W-1:0]  bin_value  = '0;
  logic                               first_bin  = 1'b0;
  logic                               out_ready  = 1'b0;
  logic                               in_ready;
  logic                               out_valid;
  logic [sbph_pkg::BAND_W-1:0]        band_index;
  logic [sbph_pkg::PIX_W-1:0]         bar_height;
  logic [sbph_pkg::PIX_W-1:0]         peak_height;
  logic                               last_band;

  // Predictor copy of the block's configuration and state.
  bit                          cfg_eighty = 1'b0;
  bit                          cfg_show   = 1'b1;
  int unsigned                 cfg_height = 400;
  int unsigned                 bin_pos    = 0;
  int unsigned                 band_pos   = 0;
  logic [sbph_pkg::MAG_W-1:0]  band_max   = '0;
  logic [sbph_pkg::PIX_W-1:0]    peak_hold [sbph_pkg::MAX_BANDS_DEF] = '{default: '0};
  logic [sbph_pkg::HEIGHT_W-1:0] prev_bar  [sbph_pkg::MAX_BANDS_DEF] = '{default: '0};

  band_result_t             pending_bars [$];
  int                       mismatch_count = 0;
  int                       cycle_count    = 0;
  int                       stall_left     = 0;
  bit                       send_steady    = 1'b0;
  bit                       ready_steady   = 1'b0;

  spectrum_band_peak_hold_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .bin_value_i  (bin_value),
    .first_bin_i  (first_bin),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .band_index_o (band_index),
    .bar_height_o (bar_height),
    .peak_height_o(peak_height),
    .last_band_o  (last_band)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Updates the band state for one accepted bin and reports the band result it closes, if any.
  task automatic predict_band_update(input logic signed [sbph_pkg::BIN_W-1:0] v,
                                     input logic f,
                                     output bit produced, output band_result_t res);
    int unsigned nb;
    int unsigned bin;
    int unsigned band;
    int unsigned band_end;
    int unsigned h;
    int unsigned peak;
    int unsigned prev;
    int          oct;
    bit [63:0]   mant;
    bit [63:0]   frac;
    bit [63:0]   lg;
    bit [63:0]   acc;
    produced = 1'b0;
    res      = '0;
    nb = cfg_eighty ? sbph_pkg::MAX_BANDS_DEF : sbph_pkg::BANDS_20;
    if (f) begin
      bin_pos  = 0;
      band_pos = 0;
      band_max = '0;
    end
    bin = bin_pos;
    if (bin_pos < 255) bin_pos++;
    band = band_pos;
    if (bin >= sbph_pkg::USED_BINS_DEF || band >= nb) return;
    if (!v[sbph_pkg::BIN_W-1] && v[sbph_pkg::MAG_W-1:0] > band_max) begin
      band_max = v[sbph_pkg::MAG_W-1:0];
    end
    if (band + 1 == nb) begin
      band_end = sbph_pkg::USED_BINS_DEF;
    end else begin
      band_end = cfg_eighty ? sbph_pkg::EDGES80[band + 1] : sbph_pkg::EDGES20[band + 1];
    end
    if (bin + 1 < band_end) return;

    // Height is floor(30*ln(max)): log2 by repeated squaring of the Q30 mantissa, then
    // scaled by 30*ln2 in Q32.
    if (band_max == '0) begin
      h = 0;
    end else begin
      oct = 0;
      for (int b = sbph_pkg::MAG_W - 1; b > 0; b--) begin
        if (band_max[b] && oct == 0) oct = b;
      end
      mant = 64'(band_max) << (30 - oct);
      frac = '0;
      repeat (32) begin
        mant = (mant * mant) >> 30;
        frac = frac << 1;
        if (mant[31]) begin
          mant    = mant >> 1;
          frac[0] = 1'b1;
        end
      end
      lg  = (64'(oct) << 32) | frac;
      acc = (lg >> 18) * sbph_pkg::THIRTY_LN2_Q32 +
            (((lg & 64'h3FFFF) * sbph_pkg::THIRTY_LN2_Q32) >> 18);
      h   = int'(acc >> 46);
    end
    if (h > sbph_pkg::HEIGHT_CAP) h = sbph_pkg::HEIGHT_CAP;
    band_max = '0;
    band_pos = band + 1;

    peak = peak_hold[band];
    if (h > peak) begin
      peak = h;
    end else if (peak > 0) begin
      peak = peak - sbph_pkg::PEAK_DECAY_STEP;
      if (peak < h) peak = h;
    end

    prev = prev_bar[band];
    if (prev >= sbph_pkg::BAR_FALL_STEP && h <= prev - sbph_pkg::BAR_FALL_STEP) begin
      h = prev - sbph_pkg::BAR_FALL_STEP;
    end
    prev_bar[band] = sbph_pkg::HEIGHT_W'(h);

    if (peak > 0 && cfg_show && peak >= cfg_height) begin
      peak = (cfg_height >= 2) ? cfg_height - 2 : 0;
    end
    peak_hold[band] = sbph_pkg::PIX_W'(peak);

    res.band = sbph_pkg::BAND_W'(band);
    res.bar  = sbph_pkg::PIX_W'((h > cfg_height) ? cfg_height : h);
    res.peak = sbph_pkg::PIX_W'(peak);
    res.last = (band + 1 == nb);
    produced = 1'b1;
  endtask

  // Offers one bin, waits for its transaction and records the band result it should cause.
  task automatic push_bin(input logic signed [sbph_pkg::BIN_W-1:0] v, input logic f,
                          input logic typed, input band_result_t want);
    int           gap;
    bit           produced;
    band_result_t res;
    gap = (send_steady || $urandom_range(0, 2) != 0) ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    bin_value <= v;
    first_bin <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_band_update(v, f, produced, res);
    if (typed) begin
      pending_bars.push_back(want);
    end else if (produced) begin
      pending_bars.push_back(res);
    end
  endtask

  // Stops the input and waits until every expected band result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!ready_steady && $urandom_range(0, 3) == 0) begin
      stall_left = gap_length();
    end
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin : result_check
    band_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bars.size() == 0) begin
        $display("%0t: unexpected result band %0d bar %0d peak %0d last %0d",
                 $time, band_index, bar_height, peak_height, last_band);
        mismatch_count++;
      end else begin
        want = pending_bars.pop_front();
        check_field("band_index", want.band, band_index);
        check_field("bar_height", want.bar, bar_height);
        check_field("peak_height", want.peak, peak_height);
        check_field("last_band", want.last, last_band);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit                                eighty_sel;
    bit                                show_sel;
    logic [sbph_pkg::PIX_W-1:0]        height_sel;
    int                                budget;
    int                                frame_len;
    int                                frame_pos;
    int                                level;
    logic                              f;
    logic signed [sbph_pkg::BIN_W-1:0] v;
    frame_len = 0;
    frame_pos = 0;
    level     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_BINS[i]) begin
      push_bin(DIRECTED_BINS[i].value, DIRECTED_BINS[i].first, DIRECTED_BINS[i].typed,
               DIRECTED_BINS[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin eighty_sel = 1'b1; show_sel = 1'b1; height_sel = 12'd400;  end
        1: begin eighty_sel = 1'b1; show_sel = 1'b0; height_sel = 12'd3;    end
        2: begin eighty_sel = 1'b0; show_sel = 1'b1; height_sel = 12'd3;    end
        3: begin eighty_sel = 1'b1; show_sel = 1'b1; height_sel = 12'd4095; end
        4: begin eighty_sel = 1'b0; show_sel = 1'b0; height_sel = 12'd4095; end
        5: begin eighty_sel = 1'b1; show_sel = 1'b1; height_sel = 12'd150;  end
        default: begin
          eighty_sel = 1'($urandom_range(0, 1));
          show_sel   = 1'($urandom_range(0, 1));
          height_sel = $urandom_range(0, 1) ? 12'($urandom_range(3, 400))
                                            : 12'($urandom_range(3, 4095));
        end
      endcase

      // The three registers go in on consecutive cycles with the write enable held high.
      cfg_we   <= 1'b1;
      cfg_idx  <= sbph_pkg::CFG_EIGHTY_BANDS;
      cfg_data <= sbph_pkg::PIX_W'(eighty_sel);
      @(posedge clk);
      cfg_idx  <= sbph_pkg::CFG_SHOW_PEAKS;
      cfg_data <= sbph_pkg::PIX_W'(show_sel);
      @(posedge clk);
      cfg_idx  <= sbph_pkg::CFG_PICTURE_HEIGHT;
      cfg_data <= height_sel;
      @(posedge clk);
      cfg_we     <= 1'b0;
      cfg_eighty = eighty_sel;
      cfg_show   = show_sel;
      cfg_height = height_sel;

      send_steady  = ($urandom_range(0, 3) == 0);
      ready_steady = ($urandom_range(0, 3) == 0);
      budget       = $urandom_range(150, 220);
      // Most phases start a fresh frame; the others carry on the frame across the mode change.
      if ($urandom_range(0, 3) != 0) frame_pos = frame_len;

      repeat (budget) begin
        if (frame_pos >= frame_len) begin
          case ($urandom_range(0, 9))
            0:       frame_len = $urandom_range(1, 254);
            1:       frame_len = 255 + $urandom_range(1, 20);
            default: frame_len = 255;
          endcase
          frame_pos = 0;
          level     = $urandom_range(0, 15);
        end
        f = (frame_pos == 0) || ($urandom_range(0, 299) == 0);
        case ($urandom_range(0, 19))
          0:       v = {1'b1, 15'($urandom)};
          1:       v = '0;
          2:       v = 16'sd32767;
          3:       v = 16'($urandom);
          default: v = 16'($urandom_range(0, (32'd1 << level) - 1));
        endcase
        frame_pos++;
        push_bin(v, f, 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
